FILE: rtl/isc_pkg.sv
`default_nettype none
package isc_pkg;

	// lamp codes for vehicle heads (one-hot) and walk heads
	localparam logic [2:0] LAMP_RED    = 3'd1;
	localparam logic [2:0] LAMP_YELLOW = 3'd2;
	localparam logic [2:0] LAMP_GREEN  = 3'd4;
	localparam logic [1:0] WALK_RED    = 2'd1;
	localparam logic [1:0] WALK_GREEN  = 2'd2;

	// normal phase numbers
	localparam logic [2:0] PHASE_0    = 3'd0;
	localparam logic [2:0] PHASE_1    = 3'd1;
	localparam logic [2:0] PHASE_2    = 3'd2;
	localparam logic [2:0] PHASE_3    = 3'd3;
	localparam logic [2:0] PHASE_4    = 3'd4;
	localparam logic [2:0] PHASE_LAST = 3'd4;

	// register map
	localparam int          ADDR_W        = 4;
	localparam int          DATA_W        = 32;
	localparam int          TICK_W        = 16;
	localparam logic [1:0]  REG_NORMAL    = 2'd0;
	localparam logic [1:0]  REG_LONG      = 2'd1;
	localparam logic [1:0]  REG_CLEAR     = 2'd2;
	localparam logic [1:0]  REG_RED       = 2'd3;
	localparam logic [15:0] NORMAL_RESET  = 16'd100;
	localparam logic [15:0] LONG_RESET    = 16'd100;
	localparam logic [15:0] CLEAR_RESET   = 16'd10;
	localparam logic [15:0] RED_RESET     = 16'd30;

	typedef enum logic [1:0] {
		EMG_NONE  = 2'd0,
		EMG_CLEAR = 2'd1,
		EMG_RED   = 2'd2
	} emg_step_t;

	typedef struct packed {
		logic [15:0] normal_ticks;
		logic [15:0] long_ticks;
		logic [15:0] clear_ticks;
		logic [15:0] red_ticks;
	} timing_cfg_t;

	typedef struct packed {
		logic [2:0] main_road;
		logic [2:0] bridge;
		logic [2:0] left_turn;
		logic [2:0] cross_car;
		logic [2:0] cross_bus;
		logic [1:0] main_walk;
		logic [1:0] cross_walk;
		logic       beacon;
	} lamps_t;

	// lamp pattern for a phase and emergency step
	function automatic lamps_t isc_lamps(input logic [2:0] phase, input emg_step_t step);
		lamps_t l;
		l = '{LAMP_RED, LAMP_RED, LAMP_RED, LAMP_RED, LAMP_RED, WALK_RED, WALK_RED, 1'b0};
		case (step)
			EMG_NONE: begin
				case (phase)
					PHASE_1: l = '{LAMP_GREEN, LAMP_RED, LAMP_GREEN, LAMP_RED, LAMP_RED,
						WALK_RED, WALK_GREEN, 1'b0};
					PHASE_2, PHASE_4: l = '{LAMP_YELLOW, LAMP_YELLOW, LAMP_YELLOW,
						LAMP_YELLOW, LAMP_YELLOW, WALK_RED, WALK_RED, 1'b0};
					PHASE_3: l = '{LAMP_RED, LAMP_RED, LAMP_RED, LAMP_GREEN, LAMP_GREEN,
						WALK_GREEN, WALK_RED, 1'b0};
					default: l = '{LAMP_GREEN, LAMP_GREEN, LAMP_RED, LAMP_RED, LAMP_RED,
						WALK_RED, WALK_GREEN, 1'b0};
				endcase
			end
			EMG_CLEAR: begin
				case (phase)
					PHASE_1: begin
						l.main_road = LAMP_YELLOW;
						l.left_turn = LAMP_YELLOW;
					end
					PHASE_2, PHASE_4: l.beacon = 1'b0;
					PHASE_3: begin
						l.cross_car = LAMP_YELLOW;
						l.cross_bus = LAMP_YELLOW;
					end
					default: begin
						l.main_road = LAMP_YELLOW;
						l.bridge    = LAMP_YELLOW;
					end
				endcase
			end
			default: l.beacon = 1'b1;
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/isc_regs.sv
`default_nettype none
module isc_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [isc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [isc_pkg::DATA_W-1:0]  pwdata,
	output logic      [isc_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output isc_pkg::timing_cfg_t             cfg
);
	import isc_pkg::*;

	timing_cfg_t cfg_q;
	logic        wr_en;
	logic [1:0]  reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_ticks <= NORMAL_RESET;
			cfg_q.long_ticks   <= LONG_RESET;
			cfg_q.clear_ticks  <= CLEAR_RESET;
			cfg_q.red_ticks    <= RED_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_NORMAL: cfg_q.normal_ticks <= pwdata[TICK_W-1:0];
				REG_LONG:   cfg_q.long_ticks   <= pwdata[TICK_W-1:0];
				REG_CLEAR:  cfg_q.clear_ticks  <= pwdata[TICK_W-1:0];
				default:    cfg_q.red_ticks    <= pwdata[TICK_W-1:0];
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (reg_sel)
			REG_NORMAL: prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.normal_ticks};
			REG_LONG:   prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.long_ticks};
			REG_CLEAR:  prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.clear_ticks};
			default:    prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.red_ticks};
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/isc_core.sv
`default_nettype none
module isc_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire isc_pkg::timing_cfg_t  cfg,
	input  wire logic                  tick_valid,
	output logic                       tick_stall,
	input  wire logic                  button_pressed,
	output logic                       lamp_valid,
	input  wire logic                  lamp_stall,
	output isc_pkg::lamps_t            lamps,
	output logic [2:0]                 phase_now
);
	import isc_pkg::*;

	// input stage
	logic        valid_s1;
	logic        button_s1;
	// controller state
	logic [2:0]  phase_q;
	emg_step_t   step_q;
	logic        latch_q;
	logic [15:0] count_q;
	// result register
	logic        out_valid_q;
	lamps_t      lamps_q;
	logic [2:0]  phase_out_q;

	logic        out_free;
	logic        adv;
	logic        accept_in;
	logic [15:0] step_len;
	logic        step_end;
	logic        latch_nxt;
	logic [2:0]  phase_nxt;
	emg_step_t   step_nxt;
	logic [15:0] count_nxt;
	logic        has_clear;

	// handshake between the stages
	assign out_free   = !out_valid_q || !lamp_stall;
	assign adv        = valid_s1 && out_free;
	assign tick_stall = valid_s1 && !out_free;
	assign accept_in  = tick_valid && !tick_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			button_s1 <= button_pressed;
		end
	end

	// length of the current step
	always_comb begin
		case (step_q)
			EMG_NONE:  step_len = cfg.normal_ticks;
			EMG_CLEAR: step_len = (phase_q == PHASE_1) ? cfg.clear_ticks : cfg.long_ticks;
			default:   step_len = (phase_q == PHASE_1) ? cfg.red_ticks : cfg.long_ticks;
		endcase
	end

	assign step_end  = ({1'b0, count_q} + 17'd1) >= {1'b0, step_len};
	assign latch_nxt = latch_q | ((step_q == EMG_NONE) & button_s1);
	assign has_clear = (phase_q == PHASE_0) || (phase_q == PHASE_1) || (phase_q == PHASE_3);

	// next state of the sequencer
	always_comb begin
		phase_nxt = phase_q;
		step_nxt  = step_q;
		count_nxt = count_q + 16'd1;
		if (step_end) begin
			count_nxt = '0;
			case (step_q)
				EMG_NONE: begin
					if (latch_nxt)
						step_nxt = has_clear ? EMG_CLEAR : EMG_RED;
					else
						phase_nxt = (phase_q == PHASE_LAST) ? PHASE_0 : phase_q + 3'd1;
				end
				EMG_CLEAR: step_nxt = EMG_RED;
				default:   step_nxt = EMG_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_0;
			step_q  <= EMG_NONE;
			latch_q <= 1'b0;
			count_q <= '0;
		end else if (adv) begin
			phase_q <= phase_nxt;
			step_q  <= step_nxt;
			latch_q <= (step_end && step_q != EMG_NONE && step_q != EMG_CLEAR) ? 1'b0 : latch_nxt;
			count_q <= count_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!lamp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lamps_q     <= isc_lamps(phase_q, step_q);
			phase_out_q <= phase_q;
		end
	end

	assign lamp_valid = out_valid_q;
	assign lamps      = lamps_q;
	assign phase_now  = phase_out_q;

`ifndef SYNTH
	a_emg_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != EMG_NONE) |-> latch_q)
		else $error("emergency step active without a latched press");
	a_clear_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == EMG_CLEAR) |-> (phase_q == PHASE_0 || phase_q == PHASE_1 ||
			phase_q == PHASE_3))
		else $error("clearance step in a phase without one");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_LAST)
		else $error("phase out of range");
	a_beacon_red: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && lamps_q.beacon) |-> (lamps_q.main_road == LAMP_RED &&
			lamps_q.cross_car == LAMP_RED && lamps_q.main_walk == WALK_RED &&
			lamps_q.cross_walk == WALK_RED))
		else $error("beacon lit while a head is not red");
	a_no_lost_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("buffered tick dropped");
`endif

endmodule
`default_nettype wire

FILE: rtl/intersection_signal_controller.sv
// Intersection signal controller.
// Tick channel: one transfer per 100 ms tick (tick_valid, tick_stall,
// button_pressed). Lamp channel: one transfer per tick giving the lamps
// shown during that tick (lamp_valid, lamp_stall, heads, beacon, phase_now).
// A tick is taken into an input register, the sequencer works on it once the
// output register is free and its lamp result sits in an output register.
// One tick per cycle is sustained while lamp_stall stays low; the only state
// loop is the phase/step/tick counter update, once per tick.
// When lamp_stall holds the result, one further tick is still taken into the
// input register; only then does tick_stall rise, combinationally from
// lamp_stall. Timing registers sit on an APB port at byte addresses 0, 4, 8
// and 12 (normal, long, clearance, short all-red), 16 bits each. The user makes
// writes only while no tick is in flight; the block does not enforce this.
// Reset (arst_n low) empties both registers, loads the default timings and
// starts phase 0 at its first tick with no press latched.
`default_nettype none
module intersection_signal_controller (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [isc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [isc_pkg::DATA_W-1:0]  pwdata,
	output logic      [isc_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        tick_valid,
	output logic                             tick_stall,
	input  wire logic                        button_pressed,
	output logic                             lamp_valid,
	input  wire logic                        lamp_stall,
	output logic      [2:0]                  main_road_head,
	output logic      [2:0]                  bridge_head,
	output logic      [2:0]                  left_turn_head,
	output logic      [2:0]                  cross_car_head,
	output logic      [2:0]                  cross_bus_head,
	output logic      [1:0]                  main_walk_head,
	output logic      [1:0]                  cross_walk_head,
	output logic                             beacon,
	output logic      [2:0]                  phase_now
);
	import isc_pkg::*;

	timing_cfg_t cfg;
	lamps_t      lamps;

	isc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	isc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.tick_valid     (tick_valid),
		.tick_stall     (tick_stall),
		.button_pressed (button_pressed),
		.lamp_valid     (lamp_valid),
		.lamp_stall     (lamp_stall),
		.lamps          (lamps),
		.phase_now      (phase_now)
	);

	// break the lamp bundle out onto the ports
	assign main_road_head  = lamps.main_road;
	assign bridge_head     = lamps.bridge;
	assign left_turn_head  = lamps.left_turn;
	assign cross_car_head  = lamps.cross_car;
	assign cross_bus_head  = lamps.cross_bus;
	assign main_walk_head  = lamps.main_walk;
	assign cross_walk_head = lamps.cross_walk;
	assign beacon          = lamps.beacon;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import isc_pkg::*;

	localparam logic [15:0] TICKS_MAX = 16'hFFFF;
	localparam int IDLE_LIMIT = 2000;
	// press flags for the opening walk through every phase and emergency path
	localparam bit [0:24] PRESS_SCRIPT = 25'b0000011101000100100010011;

	// one lamp transfer as it appears on the output ports
	typedef struct packed {
		logic [2:0] main_road;
		logic [2:0] bridge;
		logic [2:0] left_turn;
		logic [2:0] cross_car;
		logic [2:0] cross_bus;
		logic [1:0] main_walk;
		logic [1:0] cross_walk;
		logic       beacon;
		logic [2:0] phase;
	} lamp_result_t;

	// tracks the signal sequence and holds the lamp transfers still due
	class lamp_scoreboard;
		lamp_result_t due_q[$];
		int errors;
		int ticks_noted;
		int results_seen;
		logic [15:0] t_normal, t_long, t_clear, t_red;
		logic [2:0] cur_phase;
		emg_step_t emg;
		bit latched;
		logic [15:0] dwell;

		function new();
			t_normal = NORMAL_RESET;
			t_long = LONG_RESET;
			t_clear = CLEAR_RESET;
			t_red = RED_RESET;
			cur_phase = PHASE_0;
			emg = EMG_NONE;
			latched = 1'b0;
			dwell = '0;
		endfunction

		function void set_timing(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_NORMAL: t_normal = val;
				REG_LONG:   t_long = val;
				REG_CLEAR:  t_clear = val;
				default:    t_red = val;
			endcase
		endfunction

		// length of the step now running; a zero length ends after one tick
		function int unsigned step_ticks();
			if (emg == EMG_NONE)
				return t_normal;
			if (emg == EMG_CLEAR)
				return (cur_phase == PHASE_1) ? t_clear : t_long;
			return (cur_phase == PHASE_1) ? t_red : t_long;
		endfunction

		function int waiting();
			return due_q.size();
		endfunction

		// lamps for this tick, then latch, then advance the step counter
		function void note_tick(bit press);
			lamp_result_t e;
			ticks_noted++;
			case (emg)
				EMG_NONE: begin
					case (cur_phase)
						PHASE_1: e = '{LAMP_GREEN, LAMP_RED, LAMP_GREEN, LAMP_RED, LAMP_RED,
							WALK_RED, WALK_GREEN, 1'b0, cur_phase};
						PHASE_2, PHASE_4: e = '{LAMP_YELLOW, LAMP_YELLOW, LAMP_YELLOW,
							LAMP_YELLOW, LAMP_YELLOW, WALK_RED, WALK_RED, 1'b0, cur_phase};
						PHASE_3: e = '{LAMP_RED, LAMP_RED, LAMP_RED, LAMP_GREEN, LAMP_GREEN,
							WALK_GREEN, WALK_RED, 1'b0, cur_phase};
						default: e = '{LAMP_GREEN, LAMP_GREEN, LAMP_RED, LAMP_RED, LAMP_RED,
							WALK_RED, WALK_GREEN, 1'b0, cur_phase};
					endcase
				end
				EMG_CLEAR: begin
					case (cur_phase)
						PHASE_0: e = '{LAMP_YELLOW, LAMP_YELLOW, LAMP_RED, LAMP_RED, LAMP_RED,
							WALK_RED, WALK_RED, 1'b0, cur_phase};
						PHASE_1: e = '{LAMP_YELLOW, LAMP_RED, LAMP_YELLOW, LAMP_RED, LAMP_RED,
							WALK_RED, WALK_RED, 1'b0, cur_phase};
						PHASE_3: e = '{LAMP_RED, LAMP_RED, LAMP_RED, LAMP_YELLOW, LAMP_YELLOW,
							WALK_RED, WALK_RED, 1'b0, cur_phase};
						default: e = '{LAMP_RED, LAMP_RED, LAMP_RED, LAMP_RED, LAMP_RED,
							WALK_RED, WALK_RED, 1'b0, cur_phase};
					endcase
				end
				default: e = '{LAMP_RED, LAMP_RED, LAMP_RED, LAMP_RED, LAMP_RED,
					WALK_RED, WALK_RED, 1'b1, cur_phase};
			endcase
			due_q.push_back(e);

			// presses only count outside an emergency sequence
			if (emg == EMG_NONE && press)
				latched = 1'b1;

			if (int'(dwell) + 1 >= step_ticks()) begin
				dwell = '0;
				case (emg)
					EMG_NONE: begin
						if (latched)
							emg = (cur_phase == PHASE_0 || cur_phase == PHASE_1 ||
								cur_phase == PHASE_3) ? EMG_CLEAR : EMG_RED;
						else
							cur_phase = (cur_phase == PHASE_LAST) ? PHASE_0 : cur_phase + 3'd1;
					end
					EMG_CLEAR: emg = EMG_RED;
					default: begin
						emg = EMG_NONE;
						latched = 1'b0;
					end
				endcase
			end else begin
				dwell = dwell + 16'd1;
			end
		endfunction

		task report(string msg);
			if (errors < 30)
				$display("%0t  %s", $time, msg);
			errors++;
		endtask

		task match_field(string name, logic [2:0] got, logic [2:0] want);
			if (got !== want)
				report($sformatf("lamp transfer %0d: %s got %0d, want %0d",
					results_seen, name, got, want));
		endtask

		task check_lamps(lamp_result_t got);
			lamp_result_t want;
			results_seen++;
			if (due_q.size() == 0) begin
				report($sformatf("lamp transfer %0d arrived with none due", results_seen));
				return;
			end
			want = due_q.pop_front();
			match_field("main_road_head", got.main_road, want.main_road);
			match_field("bridge_head", got.bridge, want.bridge);
			match_field("left_turn_head", got.left_turn, want.left_turn);
			match_field("cross_car_head", got.cross_car, want.cross_car);
			match_field("cross_bus_head", got.cross_bus, want.cross_bus);
			match_field("main_walk_head", {1'b0, got.main_walk}, {1'b0, want.main_walk});
			match_field("cross_walk_head", {1'b0, got.cross_walk}, {1'b0, want.cross_walk});
			match_field("beacon", {2'b0, got.beacon}, {2'b0, want.beacon});
			match_field("phase_now", got.phase, want.phase);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	wire [DATA_W-1:0] prdata;
	wire pready;
	logic tick_valid = 1'b0;
	wire tick_stall;
	logic button_pressed = 1'b0;
	wire lamp_valid;
	logic lamp_stall = 1'b0;
	wire [2:0] main_road_head, bridge_head, left_turn_head, cross_car_head, cross_bus_head;
	wire [1:0] main_walk_head, cross_walk_head;
	wire beacon;
	wire [2:0] phase_now;

	lamp_scoreboard sb;
	int ticks_sent;
	int burst_left;
	int rx_cycle;
	int rx_mode;
	int rx_hold;

	intersection_signal_controller u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.button_pressed(button_pressed),
		.lamp_valid(lamp_valid),
		.lamp_stall(lamp_stall),
		.main_road_head(main_road_head),
		.bridge_head(bridge_head),
		.left_turn_head(left_turn_head),
		.cross_car_head(cross_car_head),
		.cross_bus_head(cross_bus_head),
		.main_walk_head(main_walk_head),
		.cross_walk_head(cross_walk_head),
		.beacon(beacon),
		.phase_now(phase_now)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lamp side stalls: modes change every so often, from none to long holds
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 97 == 0)
			rx_mode = $urandom_range(0, 2);
		if (rx_hold != 0)
			rx_hold--;
		else if (rx_mode == 1)
			rx_hold = ($urandom_range(0, 3) == 0) ? 1 : 0;
		else if (rx_mode == 2)
			rx_hold = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 12) : 0;
		lamp_stall <= (rx_hold != 0);
	end

	// watch both channels at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && !tick_stall)
				sb.note_tick(button_pressed);
			if (lamp_valid && !lamp_stall)
				sb.check_lamps(lamp_result_t'{main_road_head, bridge_head, left_turn_head,
					cross_car_head, cross_bus_head, main_walk_head, cross_walk_head,
					beacon, phase_now});
		end
	end

	// no transfer for this long means the block has hung
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || psel || (tick_valid && !tick_stall) || (lamp_valid && !lamp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("intersection_signal_controller: mismatch");
		$finish;
	end

	// one tick transfer; the sender runs in bursts with random gaps between
	task automatic send_tick(input bit press, input bit last);
		tick_valid <= 1'b1;
		button_pressed <= press;
		ticks_sent++;
		do @(posedge clk); while (tick_stall);
		if (last || burst_left == 0)
			tick_valid <= 1'b0;
		if (burst_left != 0) begin
			burst_left--;
		end else if (!last) begin
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 6);
		end
	endtask

	task automatic run_ticks(input int count, input int odds);
		for (int i = 0; i < count; i++)
			send_tick($urandom_range(0, odds - 1) == 0, i == count - 1);
	endtask

	// hold off until every tick has come back as a lamp transfer
	task automatic wait_drained();
		while (sb.ticks_noted != ticks_sent || sb.waiting() != 0)
			@(posedge clk);
	endtask

	// setup then access; upper data bits carry noise the block must drop
	task automatic apb_write(input logic [1:0] idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_timing(idx, val);
	endtask

	task automatic load_timing(input logic [15:0] n, l, c, r);
		apb_write(REG_NORMAL, n);
		apb_write(REG_LONG, l);
		apb_write(REG_CLEAR, c);
		apb_write(REG_RED, r);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset timings first
		run_ticks(40, 6);
		wait_drained();

		// shortest steps: every phase, each emergency path, presses on last ticks
		load_timing(16'd1, 16'd1, 16'd1, 16'd1);
		for (int i = 0; i < 25; i++)
			send_tick(PRESS_SCRIPT[i], i == 24);
		wait_drained();

		// random timings; some settings cut a running step short or stretch it out
		for (int k = 0; k < 12; k++) begin
			case (k)
				3: load_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
				7: load_timing(16'd1, TICKS_MAX, 16'd1, TICKS_MAX);
				10: load_timing(16'd2, 16'd1, TICKS_MAX, 16'd3);
				default: load_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
					16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
			endcase
			run_ticks(50, $urandom_range(2, 10));
			wait_drained();
		end

		// nothing more may come out
		repeat (6) @(posedge clk);
		if (sb.waiting() != 0)
			sb.report($sformatf("%0d lamp transfers never arrived", sb.waiting()));
		if (sb.errors == 0)
			$display("intersection_signal_controller: match");
		else
			$display("intersection_signal_controller: mismatch");
		$finish;
	end
endmodule
